// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is also evaluated while reset is asserted.
`define ASSERT_SYNC(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Assertion that is disabled while the active-low reset is asserted.
`define ASSERT_SYNC_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== hw/rtl/crcm_pkg.sv =====
// ----------------------------------------------------------------------------
// crcm_pkg
// Types and constants of the current ramp and contact monitor.
// ----------------------------------------------------------------------------
package crcm_pkg;

    typedef struct packed {
        logic [16:0] target_current;
        logic        stop_req;
        logic [1:0]  sense_mode;
        logic [11:0] sense_first;
        logic [11:0] sense_second;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic        dac_write;
        logic [11:0] dac_code;
        logic        lamp_off;
        logic        lamp_on;
        logic        blink_set;
        logic        blink_clear;
    } t_out_beat;

    typedef struct packed {
        logic start;
        logic step;
    } t_div_ctrl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_RAMP,
        S_DIV,
        S_EVAL,
        S_DONE
    } t_state;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_PAUSE     = 2'd1;
    localparam logic [1:0] STAT_STOPPED   = 2'd2;
    localparam logic [1:0] STAT_NOCONTACT = 2'd3;

    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_SECOND   = 2'd1;
    localparam logic [1:0] MODE_BOTH     = 2'd2;
    localparam logic [1:0] MODE_NONE_ALT = 2'd3;

    localparam logic [2:0] CFG_PACE_PERIOD  = 3'd0;
    localparam logic [2:0] CFG_RAMP_STEP    = 3'd1;
    localparam logic [2:0] CFG_MIN_RATIO    = 3'd2;
    localparam logic [2:0] CFG_CURRENT_SCALE = 3'd3;
    localparam logic [2:0] CFG_CLEAR_SINGLE = 3'd4;

    localparam logic [15:0] RST_PACE_PERIOD   = 16'd10;
    localparam logic [11:0] RST_RAMP_STEP     = 12'd16;
    localparam logic [11:0] RST_MIN_RATIO     = 12'd1;
    localparam logic [15:0] RST_CURRENT_SCALE = 16'd3245;
    localparam logic        RST_CLEAR_SINGLE  = 1'b1;

    localparam logic [16:0] ONE_Q8    = 17'd256;
    localparam logic [11:0] LEVEL_MAX = 12'hFFF;
    localparam logic [15:0] PACE_MAX  = 16'hFFFF;

    localparam logic [3:0] MUL_LAST = 4'd15;
    localparam logic [3:0] DIV_LAST = 4'd11;

endpackage

// ===== hw/rtl/crcm_div_serial.sv =====
// ----------------------------------------------------------------------------
// crcm_div_serial
// Restoring divider of a 12-bit level by a 13-bit divisor, one quotient
// bit per step.
// ----------------------------------------------------------------------------
module crcm_div_serial (
    input  logic                i_clk,
    input  crcm_pkg::t_div_ctrl i_ctrl,
    input  logic [11:0]         i_dividend,
    input  logic [12:0]         i_divisor,
    output logic [11:0]         o_quot
);

    logic [12:0] r_rem;
    logic [11:0] r_dvd;
    logic [12:0] r_div;
    logic [13:0] trial;
    logic [13:0] trial_sub;
    logic        ge;
    logic [12:0] n_rem;
    logic [11:0] n_dvd;

    always_comb begin
        trial     = {r_rem, r_dvd[11]};
        ge        = trial >= {1'b0, r_div};
        trial_sub = trial - {1'b0, r_div};
        n_rem     = ge ? trial_sub[12:0] : trial[12:0];
        n_dvd     = {r_dvd[10:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (i_ctrl.step) begin
            r_rem <= n_rem;
            r_dvd <= n_dvd;
        end
    end

    assign o_quot = r_dvd;

endmodule

// ===== hw/rtl/current_ramp_contact_monitor.sv =====
// ----------------------------------------------------------------------------
// current_ramp_contact_monitor
// Paced current ramp with DAC writes and a contact check by sense quotients.
// ----------------------------------------------------------------------------
// A pause or stop beat goes from acceptance straight to the output load state.
// An active ramp beat passes in order through the bit-serial scale
// multiplier, the ramp state, the two serial dividers, the evaluation state
// and the output load state, which waits while the output beat is stalled.
// One beat is in work at a time: a new beat is taken only in the idle state.
// Synchronous reset restores register defaults and clears all channel state.
module current_ramp_contact_monitor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  crcm_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output crcm_pkg::t_out_beat o_out_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data
);

    crcm_pkg::t_state    r_state;
    crcm_pkg::t_state    n_state;

    logic [15:0]         r_cfg_pace_period;
    logic [11:0]         r_cfg_ramp_step;
    logic [11:0]         r_cfg_min_ratio;
    logic [15:0]         r_cfg_current_scale;
    logic                r_cfg_clear_single;

    logic [15:0]         r_pace_count;
    logic [11:0]         r_level;
    logic                r_contact;

    crcm_pkg::t_in_beat  r_in;
    logic [33:0]         r_prod;
    logic [3:0]          r_cnt;
    crcm_pkg::t_out_beat r_res;
    logic                r_out_valid;
    crcm_pkg::t_out_beat r_out_data;

    logic                in_fire;
    logic                out_free;
    logic [15:0]         pace_inc;
    logic                pace_hit;
    logic                stop_hit;
    crcm_pkg::t_out_beat idle_res;
    logic [17:0]         mul_sum;
    logic [33:0]         n_prod;
    logic [11:0]         cur;
    logic [12:0]         up_sum;
    logic [11:0]         level_up;
    logic [11:0]         level_dn;
    logic [11:0]         level_diff;
    logic [11:0]         level_ramped;
    logic                dac_wr;
    crcm_pkg::t_div_ctrl div_ctrl;
    logic [11:0]         q_first;
    logic [11:0]         q_second;
    logic                fault;
    logic                checked;

    assign o_in_ready  = (r_state == crcm_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        in_fire  = i_in_valid && (r_state == crcm_pkg::S_IDLE);
        out_free = !r_out_valid || i_out_ready;
        pace_inc = (r_pace_count == crcm_pkg::PACE_MAX) ? r_pace_count
                                                        : r_pace_count + 16'd1;
        pace_hit = pace_inc >= r_cfg_pace_period;
        stop_hit = i_in_data.stop_req &&
                   ((r_level == 12'd0) || (i_in_data.target_current == crcm_pkg::ONE_Q8));

        idle_res = '0;
        if (!pace_hit) begin
            idle_res.status = crcm_pkg::STAT_PAUSE;
        end else if (stop_hit) begin
            idle_res.status    = crcm_pkg::STAT_STOPPED;
            idle_res.dac_write = 1'b1;
            idle_res.lamp_off  = 1'b1;
        end

        mul_sum = r_prod[33:16] + (r_prod[0] ? {1'b0, r_in.target_current} : 18'd0);
        n_prod  = {1'b0, mul_sum, r_prod[15:1]};

        cur = (r_prod[32:28] != 5'd0) ? crcm_pkg::LEVEL_MAX : r_prod[27:16];

        up_sum     = {1'b0, r_level} + {1'b0, r_cfg_ramp_step};
        level_up   = (up_sum > {1'b0, cur}) ? cur : up_sum[11:0];
        level_diff = r_level - cur;
        level_dn   = (level_diff > r_cfg_ramp_step) ? r_level - r_cfg_ramp_step : cur;
        if (r_level < cur) begin
            level_ramped = level_up;
        end else if (r_level > cur) begin
            level_ramped = level_dn;
        end else begin
            level_ramped = r_level;
        end
        dac_wr = (r_level != cur);

        checked = (r_in.sense_mode == crcm_pkg::MODE_SECOND) ||
                  (r_in.sense_mode == crcm_pkg::MODE_BOTH);
        if (r_in.sense_mode == crcm_pkg::MODE_BOTH) begin
            fault = (q_second < r_cfg_min_ratio) || (q_first < r_cfg_min_ratio);
        end else begin
            fault = (q_second < r_cfg_min_ratio);
        end
    end

    always_comb begin
        n_state       = r_state;
        div_ctrl      = '0;
        unique case (r_state)
            crcm_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (!pace_hit || stop_hit) begin
                        n_state = crcm_pkg::S_DONE;
                    end else begin
                        n_state = crcm_pkg::S_MUL;
                    end
                end
            end
            crcm_pkg::S_MUL: begin
                if (r_cnt == 4'd0) begin
                    n_state = crcm_pkg::S_RAMP;
                end
            end
            crcm_pkg::S_RAMP: begin
                div_ctrl.start = 1'b1;
                n_state        = crcm_pkg::S_DIV;
            end
            crcm_pkg::S_DIV: begin
                div_ctrl.step = 1'b1;
                if (r_cnt == 4'd0) begin
                    n_state = crcm_pkg::S_EVAL;
                end
            end
            crcm_pkg::S_EVAL: begin
                n_state = crcm_pkg::S_DONE;
            end
            crcm_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = crcm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = crcm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crcm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_pace_period   <= crcm_pkg::RST_PACE_PERIOD;
            r_cfg_ramp_step     <= crcm_pkg::RST_RAMP_STEP;
            r_cfg_min_ratio     <= crcm_pkg::RST_MIN_RATIO;
            r_cfg_current_scale <= crcm_pkg::RST_CURRENT_SCALE;
            r_cfg_clear_single  <= crcm_pkg::RST_CLEAR_SINGLE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                crcm_pkg::CFG_PACE_PERIOD:   r_cfg_pace_period   <= i_cfg_data;
                crcm_pkg::CFG_RAMP_STEP:     r_cfg_ramp_step     <= i_cfg_data[11:0];
                crcm_pkg::CFG_MIN_RATIO:     r_cfg_min_ratio     <= i_cfg_data[11:0];
                crcm_pkg::CFG_CURRENT_SCALE: r_cfg_current_scale <= i_cfg_data;
                crcm_pkg::CFG_CLEAR_SINGLE:  r_cfg_clear_single  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pace_count <= '0;
            r_level      <= '0;
            r_contact    <= 1'b0;
        end else begin
            unique case (r_state)
                crcm_pkg::S_IDLE: begin
                    if (in_fire) begin
                        if (!pace_hit) begin
                            r_pace_count <= pace_inc;
                        end else begin
                            r_pace_count <= '0;
                            if (stop_hit) begin
                                r_level <= '0;
                            end
                        end
                    end
                end
                crcm_pkg::S_RAMP: begin
                    r_level <= level_ramped;
                end
                crcm_pkg::S_EVAL: begin
                    if (checked) begin
                        r_contact <= fault;
                        if (fault && ((r_in.sense_mode == crcm_pkg::MODE_BOTH) ||
                                      r_cfg_clear_single)) begin
                            r_level <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            crcm_pkg::S_IDLE: begin
                r_in   <= i_in_data;
                r_prod <= {18'd0, r_cfg_current_scale};
                r_cnt  <= crcm_pkg::MUL_LAST;
                r_res  <= idle_res;
            end
            crcm_pkg::S_MUL: begin
                r_prod <= n_prod;
                r_cnt  <= r_cnt - 4'd1;
            end
            crcm_pkg::S_RAMP: begin
                r_cnt           <= crcm_pkg::DIV_LAST;
                r_res.dac_write <= dac_wr;
                r_res.dac_code  <= dac_wr ? level_ramped : 12'd0;
                r_res.lamp_on   <= 1'b1;
            end
            crcm_pkg::S_DIV: begin
                r_cnt <= r_cnt - 4'd1;
            end
            crcm_pkg::S_EVAL: begin
                if (checked) begin
                    r_res.blink_set   <= fault;
                    r_res.blink_clear <= !fault;
                    r_res.status      <= fault ? crcm_pkg::STAT_NOCONTACT : crcm_pkg::STAT_OK;
                end else begin
                    r_res.status <= r_contact ? crcm_pkg::STAT_NOCONTACT : crcm_pkg::STAT_OK;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == crcm_pkg::S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == crcm_pkg::S_DONE) && out_free) begin
            r_out_data <= r_res;
        end
    end

    crcm_div_serial u_div_first (
        .i_clk      (i_clk),
        .i_ctrl     (div_ctrl),
        .i_dividend (level_ramped),
        .i_divisor  ({1'b0, r_in.sense_first} + 13'd1),
        .o_quot     (q_first)
    );

    crcm_div_serial u_div_second (
        .i_clk      (i_clk),
        .i_ctrl     (div_ctrl),
        .i_dividend (level_ramped),
        .i_divisor  ({1'b0, r_in.sense_second} + 13'd1),
        .o_quot     (q_second)
    );

endmodule

// ===== hw/rtl/crcm_checker.sv =====
// ----------------------------------------------------------------------------
// crcm_checker
// Port-level checks of the current ramp and contact monitor, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crcm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input crcm_pkg::t_out_beat o_out_data
);

    `ASSERT_SYNC(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid,
        "output beat valid after reset")

    `ASSERT_SYNC_RST(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data),
        "stalled output beat changed")

    `ASSERT_SYNC_RST(a_pause_quiet, i_clk, i_rst_n,
        o_out_valid && (o_out_data.status == crcm_pkg::STAT_PAUSE) |->
        !o_out_data.dac_write && (o_out_data.dac_code == 12'd0) && !o_out_data.lamp_off &&
        !o_out_data.lamp_on && !o_out_data.blink_set && !o_out_data.blink_clear,
        "pause beat carries activity")

    `ASSERT_SYNC_RST(a_stop_beat, i_clk, i_rst_n,
        o_out_valid && (o_out_data.status == crcm_pkg::STAT_STOPPED) |->
        o_out_data.dac_write && (o_out_data.dac_code == 12'd0) && o_out_data.lamp_off &&
        !o_out_data.lamp_on,
        "stop beat malformed")

    `ASSERT_SYNC_RST(a_blink_status, i_clk, i_rst_n,
        o_out_valid && o_out_data.blink_set |->
        (o_out_data.status == crcm_pkg::STAT_NOCONTACT) && !o_out_data.blink_clear &&
        o_out_data.lamp_on,
        "blink set without contact fault status")

endmodule

bind current_ramp_contact_monitor crcm_checker u_crcm_checker (.*);

// ===== verif/current_ramp_contact_monitor_test.sv =====
// ----------------------------------------------------------------------------
// current_ramp_contact_monitor_test
// Self-checking bench for the paced current ramp and contact monitor. Input
// beats are predicted on acceptance by a cycle-free model of the channel
// (pace counter, ramp level, stored contact status), and every output beat
// is compared field by field in order. Directed beats cover stop, ramp,
// saturation, contact faults and register extremes; random traffic follows
// under several idle and stall mixes.
// ----------------------------------------------------------------------------
module current_ramp_contact_monitor_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    crcm_pkg::t_in_beat  i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    crcm_pkg::t_out_beat o_out_data;
    logic                i_cfg_we = 1'b0;
    logic [2:0]          i_cfg_idx = '0;
    logic [15:0]         i_cfg_data = '0;

    logic [15:0] cfg_pace = crcm_pkg::RST_PACE_PERIOD;
    logic [11:0] cfg_step = crcm_pkg::RST_RAMP_STEP;
    logic [11:0] cfg_ratio = crcm_pkg::RST_MIN_RATIO;
    logic [15:0] cfg_scale = crcm_pkg::RST_CURRENT_SCALE;
    logic        cfg_clear = crcm_pkg::RST_CLEAR_SINGLE;

    logic [15:0] pace_cnt = '0;
    logic [11:0] ramp_lvl = '0;
    logic        no_contact = 1'b0;

    crcm_pkg::t_out_beat ramp_results_due[$];
    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int beats_sent = 0;
    int active_steps = 0;
    int fault_steps = 0;
    int quiet_cycles = 0;

    current_ramp_contact_monitor uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic crcm_pkg::t_out_beat compute_ramp_result(input crcm_pkg::t_in_beat b);
        crcm_pkg::t_out_beat r;
        logic [32:0]         prod;
        logic [11:0]         goal;
        logic [12:0]         sum;
        int                  q1;
        int                  q2;
        logic                fault;
        r = '0;
        if (pace_cnt != crcm_pkg::PACE_MAX) pace_cnt++;
        if (pace_cnt < cfg_pace) begin
            r.status = crcm_pkg::STAT_PAUSE;
            return r;
        end
        pace_cnt = '0;
        active_steps++;
        if (b.stop_req && (ramp_lvl == '0 || b.target_current == crcm_pkg::ONE_Q8)) begin
            ramp_lvl = '0;
            r.status = crcm_pkg::STAT_STOPPED;
            r.dac_write = 1'b1;
            r.lamp_off = 1'b1;
            return r;
        end
        prod = b.target_current * cfg_scale;
        goal = (prod[32:16] > crcm_pkg::LEVEL_MAX) ? crcm_pkg::LEVEL_MAX : prod[27:16];
        if (ramp_lvl < goal) begin
            sum = {1'b0, ramp_lvl} + cfg_step;
            ramp_lvl = (sum > goal) ? goal : sum[11:0];
            r.dac_write = 1'b1;
            r.dac_code = ramp_lvl;
        end else if (ramp_lvl > goal) begin
            ramp_lvl = (ramp_lvl - goal > cfg_step) ? ramp_lvl - cfg_step : goal;
            r.dac_write = 1'b1;
            r.dac_code = ramp_lvl;
        end
        r.lamp_on = 1'b1;
        q1 = int'(ramp_lvl) / (int'(b.sense_first) + 1);
        q2 = int'(ramp_lvl) / (int'(b.sense_second) + 1);
        if (b.sense_mode == crcm_pkg::MODE_BOTH || b.sense_mode == crcm_pkg::MODE_SECOND) begin
            fault = (q2 < int'(cfg_ratio)) ||
                    (b.sense_mode == crcm_pkg::MODE_BOTH && q1 < int'(cfg_ratio));
            if (fault) begin
                r.blink_set = 1'b1;
                no_contact = 1'b1;
                fault_steps++;
                if (b.sense_mode == crcm_pkg::MODE_BOTH || cfg_clear) ramp_lvl = '0;
            end else begin
                r.blink_clear = 1'b1;
                no_contact = 1'b0;
            end
        end
        r.status = no_contact ? crcm_pkg::STAT_NOCONTACT : crcm_pkg::STAT_OK;
        return r;
    endfunction

    function automatic crcm_pkg::t_in_beat make_beat(input logic [16:0] target,
                                                     input logic stop,
                                                     input logic [1:0] mode,
                                                     input logic [11:0] first, second);
        crcm_pkg::t_in_beat b;
        b.target_current = target;
        b.stop_req = stop;
        b.sense_mode = mode;
        b.sense_first = first;
        b.sense_second = second;
        return b;
    endfunction

    function automatic logic [11:0] random_reading();
        return ($urandom_range(1) != 0) ? 12'($urandom_range(15)) : 12'($urandom_range(4095));
    endfunction

    function automatic crcm_pkg::t_in_beat random_beat();
        logic [16:0] target;
        case ($urandom_range(3))
            0: target = crcm_pkg::ONE_Q8;
            1: target = 17'($urandom_range(4000));
            default: target = 17'($urandom_range(131071));
        endcase
        return make_beat(target, $urandom_range(99) < 15, 2'($urandom_range(3)),
                         random_reading(), random_reading());
    endfunction

    task automatic send_beat(input crcm_pkg::t_in_beat beat);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        ramp_results_due.push_back(compute_ramp_result(beat));
        beats_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (ramp_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [15:0] pace, input logic [11:0] step,
                                 input logic [11:0] ratio, input logic [15:0] scale,
                                 input logic clear);
        logic [2:0]  regs [5] = '{crcm_pkg::CFG_PACE_PERIOD, crcm_pkg::CFG_RAMP_STEP,
                                  crcm_pkg::CFG_MIN_RATIO, crcm_pkg::CFG_CURRENT_SCALE,
                                  crcm_pkg::CFG_CLEAR_SINGLE};
        logic [15:0] vals [5];
        vals = '{pace, 16'(step), 16'(ratio), scale, 16'(clear)};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= regs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_pace = pace;
        cfg_step = step;
        cfg_ratio = ratio;
        cfg_scale = scale;
        cfg_clear = clear;
    endtask

    task automatic check_field(input string name, input logic [11:0] want, got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        crcm_pkg::t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (ramp_results_due.size() == 0) begin
                $error("result beat %h arrived with nothing expected", o_out_data);
                mismatches++;
            end else begin
                want = ramp_results_due.pop_front();
                check_field("status", want.status, o_out_data.status);
                check_field("dac_write", want.dac_write, o_out_data.dac_write);
                check_field("dac_code", want.dac_code, o_out_data.dac_code);
                check_field("lamp_off", want.lamp_off, o_out_data.lamp_off);
                check_field("lamp_on", want.lamp_on, o_out_data.lamp_on);
                check_field("blink_set", want.blink_set, o_out_data.blink_set);
                check_field("blink_clear", want.blink_clear, o_out_data.blink_clear);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[current_ramp_contact_monitor] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_stop_and_ramp();
        load_settings(16'd1, 12'd16, 12'd1, crcm_pkg::RST_CURRENT_SCALE, 1'b1);
        send_beat(make_beat(17'd0, 1'b1, crcm_pkg::MODE_NONE, 12'd0, 12'd0));
        send_beat(make_beat(17'h1FFFF, 1'b0, crcm_pkg::MODE_NONE, 12'd0, 12'd0));
        send_beat(make_beat(17'h1FFFF, 1'b0, crcm_pkg::MODE_NONE_ALT, 12'hFFF, 12'hFFF));
        send_beat(make_beat(17'd1000, 1'b1, crcm_pkg::MODE_NONE, 12'd0, 12'd0));
        send_beat(make_beat(crcm_pkg::ONE_Q8, 1'b1, crcm_pkg::MODE_NONE, 12'd0, 12'd0));
        send_beat(make_beat(17'h1FFFF, 1'b0, crcm_pkg::MODE_BOTH, 12'd0, 12'd0));
        send_beat(make_beat(17'h1FFFF, 1'b0, crcm_pkg::MODE_SECOND, 12'd0, 12'hFFF));
        send_beat(make_beat(17'h1FFFF, 1'b0, crcm_pkg::MODE_NONE, 12'd0, 12'd0));
        send_beat(make_beat(17'h1FFFF, 1'b0, crcm_pkg::MODE_BOTH, 12'hFFF, 12'd0));
        send_beat(make_beat(17'd0, 1'b0, crcm_pkg::MODE_NONE, 12'hAAA, 12'h555));
        settle();
    endtask

    task automatic test_register_extremes();
        load_settings(16'd1, 12'd4095, 12'd4095, 16'hFFFF, 1'b0);
        send_beat(make_beat(17'h1FFFF, 1'b0, crcm_pkg::MODE_SECOND, 12'd0, 12'd0));
        send_beat(make_beat(17'h1FFFF, 1'b0, crcm_pkg::MODE_SECOND, 12'd0, 12'd1));
        settle();
        load_settings(16'd0, 12'd0, 12'd0, 16'd0, 1'b1);
        send_beat(make_beat(17'd1234, 1'b0, crcm_pkg::MODE_BOTH, 12'hFFF, 12'hFFF));
        send_beat(make_beat(17'h1FFFF, 1'b0, crcm_pkg::MODE_SECOND, 12'hFFF, 12'hFFF));
        settle();
        load_settings(16'd1, 12'd4095, 12'd4095, 16'hFFFF, 1'b1);
        send_beat(make_beat(17'd0, 1'b0, crcm_pkg::MODE_BOTH, 12'd0, 12'd0));
        settle();
    endtask

    task automatic test_pace_counter();
        load_settings(16'd3, 12'd100, 12'd0, 16'd20000, 1'b1);
        for (int n = 0; n < 7; n++) send_beat(random_beat());
        settle();
        load_settings(16'd20, 12'd100, 12'd0, 16'd20000, 1'b1);
        for (int n = 0; n < 40; n++) send_beat(random_beat());
        settle();
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int count);
        logic [11:0] ratio;
        logic [11:0] step;
        ratio = ($urandom_range(99) < 80) ? 12'($urandom_range(3)) : 12'($urandom_range(4095));
        step = ($urandom_range(1) != 0) ? 12'($urandom_range(64)) : 12'($urandom_range(4095));
        load_settings(16'($urandom_range(3)), step, ratio, 16'($urandom_range(65535)),
                      1'($urandom_range(1)));
        send_idle_pct = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++) send_beat(random_beat());
        settle();
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_stop_and_ramp();
        test_register_extremes();
        test_pace_counter();
        test_random_traffic(0, 0, 85);
        test_random_traffic(84, 0, 85);
        test_random_traffic(0, 84, 85);
        test_random_traffic(37, 37, 85);
        $display("Run covered %0d beats, %0d active steps and %0d contact faults",
                 beats_sent, active_steps, fault_steps);
        $display("under stop, ramp, pace and register extremes with idle and stall mixes.");
        if (mismatches == 0 && ramp_results_due.size() == 0) begin
            $display("[current_ramp_contact_monitor] OK");
        end else begin
            $display("[current_ramp_contact_monitor] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/crcm_pkg.sv
hw/rtl/crcm_div_serial.sv
hw/rtl/current_ramp_contact_monitor.sv
hw/rtl/crcm_checker.sv
verif/current_ramp_contact_monitor_test.sv
